FILE: src/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Queue depth, the widths that follow from it, and the field widths
    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;
    localparam int PRI_W     = 16;
    localparam int INFO_W    = 32;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // Input word
    typedef struct packed {
        logic                     op;
        logic signed [INFO_W-1:0] entry_info;
        logic signed [PRI_W-1:0]  entry_priority;
    } in_t;

    // Result word
    typedef struct packed {
        logic                     out_valid;
        logic signed [INFO_W-1:0] out_info;
        logic signed [PRI_W-1:0]  out_priority;
        logic [1:0]               status;
        logic signed [PRI_W-1:0]  top_priority;
        logic                     is_empty;
        logic [OUT_CNT_W-1:0]     entry_count;
    } out_t;

    // One stored entry
    typedef struct packed {
        logic signed [PRI_W-1:0]  priority_val;
        logic signed [INFO_W-1:0] info;
    } entry_t;

    // Broadcast control to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

FILE: src/sorted_priority_queue_top.sv
`timescale 1ns / 1ps

// Sorted priority queue, a row of CAPACITY slot cells kept in descending
// priority order with the head in the first cell.
// Command channel: a word on cmd is taken at a rising edge where start is
// high and busy is low. op selects enqueue or dequeue. busy stays low, so a
// command may be issued in every cycle.
// Result channel: done is high for exactly one cycle, in the cycle after the
// command is taken, with the result word on result. The receiver cannot hold
// it off and must take it in that cycle.
// Throughput is one command per cycle: every cell compares its priority with
// the new entry and shifts against its neighbours in the same cycle, so
// insertion and removal cost one step. Equal priorities leave in arrival
// order. An enqueue on a full queue is dropped and reports full, a dequeue
// on an empty queue reports underflow.
// Reset (rst_n low) empties the queue and clears done; slot contents are
// not cleared, only the count of filled slots.
module sorted_priority_queue_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::in_t  cmd,
    output logic          done,
    output spq_pkg::out_t result
);

    localparam int N = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0]  count_reg;
    logic [spq_pkg::CNT_W-1:0]  count_next;
    logic                       done_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    spq_pkg::entry_t            out_entry_reg;
    spq_pkg::entry_t            out_entry_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;

    logic                       accept;
    logic                       is_full;
    logic                       is_void;
    spq_pkg::cell_ctl_t         ctl;
    spq_pkg::entry_t            cell_entry [N];
    logic                       cell_keep  [N];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign is_full = (count_reg == spq_pkg::CNT_W'(N));
    assign is_void = (count_reg == '0);

    // Drive the cell row
    always_comb
    begin
        ctl.enq                    = accept && (cmd.op == spq_pkg::OP_ENQ) && !is_full;
        ctl.deq                    = accept && (cmd.op == spq_pkg::OP_DEQ) && !is_void;
        ctl.new_entry.priority_val = cmd.entry_priority;
        ctl.new_entry.info         = cmd.entry_info;
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_k;
            if (gi == 0)
            begin : g_head
                assign left_e = cell_entry[gi];
                assign left_k = 1'b1;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end
            if (gi == N - 1)
            begin : g_tail
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (spq_pkg::CNT_W'(gi) < count_reg),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .keep        (cell_keep[gi])
            );
        end
    endgenerate

    // Work out count and the per-command part of the result
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = 1'b0;
        out_entry_next = '0;
        status_next    = spq_pkg::STAT_OK;
        if (ctl.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.deq)
        begin
            count_next     = count_reg - 1'b1;
            out_valid_next = 1'b1;
            out_entry_next = cell_entry[0];
        end
        else if (accept && (cmd.op == spq_pkg::OP_ENQ))
        begin
            status_next = spq_pkg::STAT_FULL;
        end
        else if (accept)
        begin
            status_next = spq_pkg::STAT_UNDERFLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg <= out_valid_next;
            out_entry_reg <= out_entry_next;
            status_reg    <= status_next;
        end
    end

    // Present the result word; top priority comes straight from the head cell, empty flag and count from count_reg
    assign done = done_reg;
    always_comb
    begin
        result.out_valid    = out_valid_reg;
        result.out_info     = out_entry_reg.info;
        result.out_priority = out_entry_reg.priority_val;
        result.status       = status_reg;
        result.top_priority = is_void ? '0 : cell_entry[0].priority_val;
        result.is_empty     = is_void;
        result.entry_count  = spq_pkg::OUT_CNT_W'(count_reg);
    end

endmodule

FILE: src/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_keep,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Hold the slot while it is occupied and its priority is at least that of the new entry
    assign keep  = occupied && (entry_reg.priority_val >= ctl.new_entry.priority_val);
    assign entry = entry_reg;

    // Insert the new entry at the first free or lower slot, shift right behind it,
    // or advance left on a dequeue
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.enq && !keep)
        begin
            entry_next = left_keep ? ctl.new_entry : left_entry;
        end
        else if (ctl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: src/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input spq_pkg::in_t  cmd,
    input logic          done,
    input spq_pkg::out_t result
);

    // Every accepted word gets its result in the next cycle
    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("result missing after accepted word");

    // No result without a command
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without accepted word");

    // A returned entry always reports ok
    a_valid_ok : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_valid |-> result.status == spq_pkg::STAT_OK)
        else $error("returned entry with error status");

    // Empty queue reports zero count and zero top priority
    a_empty_view : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_empty |-> result.entry_count == '0 && result.top_priority == '0)
        else $error("empty flag disagrees with count or top");

    // Underflow only on dequeue
    a_underflow_deq : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.op == spq_pkg::OP_ENQ |=>
        result.status != spq_pkg::STAT_UNDERFLOW)
        else $error("underflow reported for enqueue");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

FILE: bench/spq_checker.sv
`timescale 1ns / 1ps

module spq_scoreboard
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  in_t  cmd,
    input  logic done,
    input  out_t result,
    output int   mismatches,
    output int   words_due
);

    // Shadow copy of the queue, head in slot 0
    logic signed [PRI_W-1:0]  shadow_pri [CAPACITY];
    logic signed [INFO_W-1:0] shadow_info[CAPACITY];
    int                       shadow_fill;

    // Results still to arrive, oldest first
    out_t due_results[$];

    initial
    begin
        shadow_fill = 0;
        mismatches  = 0;
        words_due   = 0;
    end

    // Apply one command word to the shadow queue and return its result word
    task automatic apply_queue_op(input in_t w, output out_t r);
        int pos;
        int i;
        r = '0;
        if (w.op == OP_ENQ)
        begin
            if (shadow_fill >= CAPACITY)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                // Walk past every entry of greater or equal priority
                pos = 0;
                while (pos < shadow_fill && shadow_pri[pos] >= w.entry_priority)
                    pos++;
                for (i = shadow_fill; i > pos; i--)
                begin
                    shadow_pri[i]  = shadow_pri[i-1];
                    shadow_info[i] = shadow_info[i-1];
                end
                shadow_pri[pos]  = w.entry_priority;
                shadow_info[pos] = w.entry_info;
                shadow_fill++;
                r.status = STAT_OK;
            end
        end
        else
        begin
            if (shadow_fill == 0)
            begin
                r.status = STAT_UNDERFLOW;
            end
            else
            begin
                r.out_valid    = 1'b1;
                r.out_info     = shadow_info[0];
                r.out_priority = shadow_pri[0];
                for (i = 1; i < shadow_fill; i++)
                begin
                    shadow_pri[i-1]  = shadow_pri[i];
                    shadow_info[i-1] = shadow_info[i];
                end
                shadow_fill--;
                r.status = STAT_OK;
            end
        end
        r.top_priority = (shadow_fill > 0) ? shadow_pri[0] : '0;
        r.is_empty     = (shadow_fill == 0);
        r.entry_count  = OUT_CNT_W'(shadow_fill);
    endtask

    // Count a bad field, report only the first ten
    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    endtask

    task automatic compare_word(input out_t want, input out_t got);
        if (got.out_valid !== want.out_valid)
            flag_field("out_valid", want.out_valid, got.out_valid);
        if (got.out_info !== want.out_info)
            flag_field("out_info", want.out_info, got.out_info);
        if (got.out_priority !== want.out_priority)
            flag_field("out_priority", want.out_priority, got.out_priority);
        if (got.status !== want.status)
            flag_field("status", want.status, got.status);
        if (got.top_priority !== want.top_priority)
            flag_field("top_priority", want.top_priority, got.top_priority);
        if (got.is_empty !== want.is_empty)
            flag_field("is_empty", want.is_empty, got.is_empty);
        if (got.entry_count !== want.entry_count)
            flag_field("entry_count", want.entry_count, got.entry_count);
    endtask

    // Predict on every accepted command, then match the result strobe
    always @(posedge clk)
    begin
        out_t predicted;
        out_t oldest;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_queue_op(cmd, predicted);
                due_results.push_back(predicted);
            end
            if (done === 1'b1)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with none expected: %h",
                                 $realtime, result);
                end
                else
                begin
                    oldest = due_results.pop_front();
                    compare_word(oldest, result);
                end
            end
            else if (done !== 1'b0)
            begin
                flag_field("done", 32'd0, done);
            end
            words_due = due_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int PHASE_ITEMS = 617;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  cmd;
    logic done;
    out_t result;
    int   mismatches;
    int   words_due;
    int   gap_pct;

    sorted_priority_queue_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    spq_scoreboard u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Give up if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic signed [PRI_W-1:0] pick_priority();
        case ($urandom_range(9))
            0: pick_priority = 16'sh8000;
            1: pick_priority = 16'sh7fff;
            2, 3, 4: pick_priority = PRI_W'($signed($urandom_range(4)) - 2);
            default: pick_priority = PRI_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [INFO_W-1:0] pick_info();
        case ($urandom_range(15))
            0: pick_info = 32'sh80000000;
            1: pick_info = 32'sh7fffffff;
            default: pick_info = $urandom;
        endcase
    endfunction

    // Hold start low for a random gap, then present the word until taken
    task automatic send_word(input in_t w);
        logic [63:0] noise;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            noise = {$urandom, $urandom};
            start <= 1'b0;
            cmd   <= noise[$bits(in_t)-1:0];
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic enqueue(input logic signed [PRI_W-1:0] p,
                           input logic signed [INFO_W-1:0] info);
        in_t w;
        w.op             = OP_ENQ;
        w.entry_priority = p;
        w.entry_info     = info;
        send_word(w);
    endtask

    task automatic dequeue();
        in_t w;
        w.op             = OP_DEQ;
        w.entry_priority = PRI_W'($urandom);
        w.entry_info     = $urandom;
        send_word(w);
    endtask

    initial
    begin
        int phase;
        int n;
        int lean;
        in_t w;

        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        gap_pct = 6;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Underflow, extreme fields, ties, fill to capacity, drop when full
        dequeue();
        enqueue(16'sh7fff, 32'sh7fffffff);
        enqueue(16'sh8000, 32'sh80000000);
        enqueue(16'sh0000, 32'sh00000000);
        enqueue(16'shffff, 32'shffffffff);
        enqueue(16'sd5, 32'sd1);
        enqueue(16'sd5, 32'sd2);
        enqueue(16'sd5, 32'sd3);
        enqueue(16'sh8000, 32'sd4);
        enqueue(16'sh7fff, 32'sd5);
        for (n = 0; n < 7; n++)
            enqueue(PRI_W'(n * 1000 - 3000), 32'h100 + n);
        enqueue(16'sh0000, 32'shdeadbeef);
        repeat (5) dequeue();

        // Random traffic, leaning towards full or empty in stretches
        for (phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 6 : (phase == 1) ? 51 : 0;
            lean = 50;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 30 == 0)
                begin
                    case ($urandom_range(2))
                        0: lean = 20;
                        1: lean = 50;
                        default: lean = 85;
                    endcase
                end
                w.op             = ($urandom_range(99) < lean) ? OP_ENQ : OP_DEQ;
                w.entry_priority = pick_priority();
                w.entry_info     = pick_info();
                send_word(w);
            end
        end

        // Drop start and drain the last results
        @(negedge clk);
        start <= 1'b0;
        while (words_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
